>>> rtl/core/dec_pkg.sv
// Shared constants and types for the Doppler energy correction block.
package dec_pkg;

    localparam int BETA_FRAC_BITS_DEF = 16;

    localparam int POS_W     = 18;
    localparam int BETA_W    = 16;
    localparam int ENERGY_W  = 20;
    localparam int OUT_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 18;

    localparam logic [BETA_W-1:0] BETA_AVERAGE_RST  = 16'd28147;
    localparam logic [BETA_W-1:0] BETA_MEAN_TOF_RST = 16'd28147;
    localparam logic [POS_W-1:0]  DECAY_OFFSET_RST  = 18'd0;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_ZERO = 2'd1,
        STATUS_SAT  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BETA_AVERAGE   = 2'd0,
        CFG_BETA_MEAN_TOF  = 2'd1,
        CFG_DECAY_OFFSET_Z = 2'd2
    } cfg_idx_t;

endpackage

>>> rtl/core/dec_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module dec_isqrt #(
    parameter int W = 42
) (
    input  logic           clk,
    input  logic           adv,
    input  logic [W-1:0]   x,
    output logic [W/2-1:0] root
);
    localparam int STAGES = W / 2;

    logic [W-1:0] x_reg [STAGES];
    logic [W-1:0] r_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic [W-1:0] x_in;
        logic [W-1:0] r_in;
        logic [W-1:0] b;
        logic [W:0]   t;
        logic [W-1:0] x_next;
        logic [W-1:0] r_next;

        if (i == 0) begin : g_first
            assign x_in = x;
            assign r_in = '0;
        end else begin : g_rest
            assign x_in = x_reg[i-1];
            assign r_in = r_reg[i-1];
        end

        always_comb
        begin
            b = W'(1) << (W - 2 - 2 * i);
            t = (W+1)'(r_in) + (W+1)'(b);
            if ((W+1)'(x_in) >= t)
            begin
                x_next = W'((W+1)'(x_in) - t);
                r_next = (r_in >> 1) + b;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i] <= x_next;
                r_reg[i] <= r_next;
            end
        end
    end

    assign root = r_reg[STAGES-1][W/2-1:0];

endmodule

>>> rtl/core/dec_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module dec_div #(
    parameter int DW    = 42,
    parameter int STEPS = 17
) (
    input  logic             clk,
    input  logic             adv,
    input  logic [DW-1:0]    rem0,
    input  logic [STEPS-1:0] low,
    input  logic [DW-1:0]    div,
    output logic [STEPS-1:0] quo
);
    // rem0 must be below div; low bits enter MSB first
    logic [DW-1:0]    r_reg [STEPS];
    logic [DW-1:0]    d_reg [STEPS];
    logic [STEPS-1:0] l_reg [STEPS];
    logic [STEPS-1:0] q_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic [DW-1:0]    r_in;
        logic [DW-1:0]    d_in;
        logic [STEPS-1:0] l_in;
        logic [STEPS-1:0] q_in;
        logic [DW:0]      r2;
        logic             ge;

        if (k == 0) begin : g_first
            assign r_in = rem0;
            assign d_in = div;
            assign l_in = low;
            assign q_in = '0;
        end else begin : g_rest
            assign r_in = r_reg[k-1];
            assign d_in = d_reg[k-1];
            assign l_in = l_reg[k-1];
            assign q_in = q_reg[k-1];
        end

        assign r2 = {r_in, l_in[STEPS-1]};
        assign ge = r2 >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[k] <= ge ? DW'(r2 - {1'b0, d_in}) : DW'(r2);
                d_reg[k] <= d_in;
                l_reg[k] <= l_in << 1;
                q_reg[k] <= {q_in[STEPS-2:0], ge};
            end
        end
    end

    assign quo = q_reg[STEPS-1];

endmodule

>>> rtl/core/doppler_energy_correction.sv
// Doppler energy correction: top level, pipelined datapath with output skid.
// Depth: set by the length square roots (21 stages), cosine divider (BETA_FRAC_BITS + 1)
//   and energy divider (24).
// Throughput: one item per cycle; an output stall freezes the pipeline once the skid is full.
// Reset: rst_n clears valid bits, skid and config registers (to their defaults);
//   datapath registers are not reset, and no clearing pass is needed.
module doppler_energy_correction #(
    parameter int BETA_FRAC_BITS = dec_pkg::BETA_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dec_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dec_pkg::CFG_W-1:0]          cfg_data,
    // input items
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [dec_pkg::POS_W-1:0]   gamma_pos_x,
    input  logic signed [dec_pkg::POS_W-1:0]   gamma_pos_y,
    input  logic signed [dec_pkg::POS_W-1:0]   gamma_pos_z,
    input  logic signed [dec_pkg::POS_W-1:0]   vertex_x,
    input  logic signed [dec_pkg::POS_W-1:0]   vertex_y,
    input  logic signed [dec_pkg::POS_W-1:0]   vertex_z,
    input  logic signed [dec_pkg::POS_W-1:0]   track_pos_x,
    input  logic signed [dec_pkg::POS_W-1:0]   track_pos_y,
    input  logic signed [dec_pkg::POS_W-1:0]   track_pos_z,
    input  logic [dec_pkg::ENERGY_W-1:0]       measured_energy,
    input  logic [dec_pkg::BETA_W-1:0]         measured_beta,
    // result items
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [dec_pkg::OUT_W-1:0]          doppler_energy,
    output logic [1:0]                         status
);
    import dec_pkg::*;

    localparam int F      = BETA_FRAC_BITS;
    localparam int COMP_W = POS_W + 2;          // vector component
    localparam int PROD_W = 2 * COMP_W;         // component product
    localparam int SUM_W  = PROD_W + 2;         // sum of three products
    localparam int LEN_W  = SUM_W / 2;          // vector length
    localparam int DSQ_W  = 2 * F + 2;          // 1 - beta^2 in Q.2F, padded even
    localparam int NUM_W  = 2 * F + 2;
    localparam int GW     = F + 2;              // 1 - beta*cos in Q.F
    localparam int EGW    = ENERGY_W + GW;
    localparam int NW     = EGW + 2;            // rounding numerator
    localparam int DDW    = F + 2;              // twice the sqrt term
    localparam int SH_L   = (F >= BETA_W) ? F - BETA_W : 0;
    localparam int SH_R   = (F >= BETA_W) ? 0 : BETA_W - F;
    localparam int BCW    = BETA_W + 1 + SH_L;

    localparam int SQ_LAT = SUM_W / 2;
    localparam int CD_LAT = F + 1;
    localparam int ED_LAT = OUT_W;
    localparam int TOT    = 3 + SQ_LAT + 2 + CD_LAT + 6 + ED_LAT;

    localparam logic [BCW-1:0]   BETA_MAX = BCW'((64'd1 << F) - 64'd1);
    localparam logic [F:0]       ONE      = {1'b1, {F{1'b0}}};
    localparam logic [NUM_W-1:0] ONE_SQ   = NUM_W'(1) << (2 * F);
    localparam logic [NUM_W-1:0] HALF     = NUM_W'(1) << (F - 1);
    localparam logic [DSQ_W-1:0] ONE_SQD  = DSQ_W'(1) << (2 * F);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [BETA_W-1:0]       beta_avg_reg;
    logic [BETA_W-1:0]       beta_tof_reg;
    logic signed [POS_W-1:0] dz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_avg_reg <= BETA_AVERAGE_RST;
            beta_tof_reg <= BETA_MEAN_TOF_RST;
            dz_reg       <= DECAY_OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BETA_AVERAGE:   beta_avg_reg <= cfg_data[BETA_W-1:0];
                CFG_BETA_MEAN_TOF:  beta_tof_reg <= cfg_data[BETA_W-1:0];
                CFG_DECAY_OFFSET_Z: dz_reg       <= cfg_data[POS_W-1:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: whole pipeline moves together; skid register
    // takes the leaving item when the output is stalled.
    // ---------------------------------------------------------------
    logic adv;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic vld_reg [TOT];

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < TOT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage A: vectors from vertex, effective beta
    // ---------------------------------------------------------------
    logic signed [COMP_W-1:0] ax_next, ay_next, az_next, bx_next, by_next, bz_next;
    logic signed [BETA_W+1:0] bsum;
    logic [BCW-1:0]           bconv;
    logic [F-1:0]             beta_next;

    always_comb
    begin
        ax_next = COMP_W'(gamma_pos_x) - COMP_W'(vertex_x);
        ay_next = COMP_W'(gamma_pos_y) - COMP_W'(vertex_y);
        az_next = COMP_W'(gamma_pos_z) - COMP_W'(vertex_z) - COMP_W'(dz_reg);
        bx_next = COMP_W'(track_pos_x) - COMP_W'(vertex_x);
        by_next = COMP_W'(track_pos_y) - COMP_W'(vertex_y);
        bz_next = COMP_W'(track_pos_z) - COMP_W'(vertex_z) - COMP_W'(dz_reg);

        bsum = $signed({2'b00, beta_avg_reg}) + $signed({2'b00, measured_beta})
             - $signed({2'b00, beta_tof_reg});
        if (bsum[BETA_W+1])
            bconv = '0;
        else
            bconv = (BCW'(bsum[BETA_W:0]) << SH_L) >> SH_R;
        beta_next = (bconv > BETA_MAX) ? BETA_MAX[F-1:0] : bconv[F-1:0];
    end

    logic signed [COMP_W-1:0] ax_a_reg, ay_a_reg, az_a_reg, bx_a_reg, by_a_reg, bz_a_reg;
    logic [F-1:0]             beta_a_reg;
    logic [ENERGY_W-1:0]      en_a_reg;

    // Stage B: products
    logic signed [PROD_W-1:0] sax_b_reg, say_b_reg, saz_b_reg;
    logic signed [PROD_W-1:0] sbx_b_reg, sby_b_reg, sbz_b_reg;
    logic signed [PROD_W-1:0] pdx_b_reg, pdy_b_reg, pdz_b_reg;
    logic [2*F-1:0]           bb_b_reg;
    logic [F-1:0]             beta_b_reg;
    logic [ENERGY_W-1:0]      en_b_reg;
    logic                     zero_b_reg;

    // Stage C: sums
    logic [SUM_W-1:0]         s1_c_reg, s2_c_reg;
    logic signed [SUM_W-1:0]  dot_c_reg;
    logic [DSQ_W-1:0]         dsq_c_reg;
    logic [F-1:0]             beta_c_reg;
    logic [ENERGY_W-1:0]      en_c_reg;
    logic                     zero_c_reg;

    // side line beside the length square roots
    logic signed [SUM_W-1:0]  sq_dot_reg  [SQ_LAT];
    logic                     sq_zero_reg [SQ_LAT];
    logic [F-1:0]             sq_beta_reg [SQ_LAT];
    logic [DSQ_W-1:0]         sq_dsq_reg  [SQ_LAT];
    logic [ENERGY_W-1:0]      sq_en_reg   [SQ_LAT];
    logic [LEN_W-1:0]         len1, len2;

    // Stage P: length product, |dot|
    logic [SUM_W-1:0]         p_p_reg, mag_p_reg;
    logic                     neg_p_reg, zero_p_reg;
    logic [F-1:0]             beta_p_reg;
    logic [DSQ_W-1:0]         dsq_p_reg;
    logic [ENERGY_W-1:0]      en_p_reg;

    // Stage Q: clamp test, divider feed
    logic [SUM_W-1:0]         p_q_reg, rem_q_reg;
    logic                     clamp_q_reg, neg_q_reg, zero_q_reg;
    logic [F-1:0]             beta_q_reg;
    logic [DSQ_W-1:0]         dsq_q_reg;
    logic [ENERGY_W-1:0]      en_q_reg;

    // side line beside the cosine divider and the sqrt(1 - beta^2) unit
    logic                     cd_clamp_reg [CD_LAT];
    logic                     cd_neg_reg   [CD_LAT];
    logic                     cd_zero_reg  [CD_LAT];
    logic [F-1:0]             cd_beta_reg  [CD_LAT];
    logic [ENERGY_W-1:0]      cd_en_reg    [CD_LAT];
    logic [F:0]               cos_q;
    logic [F:0]               d_root;

    // Stage M: cosine magnitude
    logic [F:0]               cmag_m_reg, d_m_reg;
    logic                     neg_m_reg, zero_m_reg;
    logic [F-1:0]             beta_m_reg;
    logic [ENERGY_W-1:0]      en_m_reg;

    // Stage K: beta * cos
    logic [2*F:0]             bc_k_reg;
    logic [F:0]               d_k_reg;
    logic                     neg_k_reg, zero_k_reg;
    logic [ENERGY_W-1:0]      en_k_reg;

    // Stage G: rounded 1 - beta*cos
    logic [GW-1:0]            g_g_reg;
    logic [F:0]               d_g_reg;
    logic                     zero_g_reg;
    logic [ENERGY_W-1:0]      en_g_reg;

    // Stage E: energy * g
    logic [EGW-1:0]           eg_e_reg;
    logic [F:0]               d_e_reg;
    logic                     zero_e_reg;

    // Stage N: rounding numerator and divisor
    logic [NW-1:0]            n_n_reg;
    logic [DDW-1:0]           dd_n_reg;
    logic                     zero_n_reg;

    // Stage S: saturation test, divider feed
    logic [DDW-1:0]           rem_s_reg, dd_s_reg;
    logic [OUT_W-1:0]         low_s_reg;
    logic                     sat_s_reg, zero_s_reg;

    // side line beside the energy divider
    logic                     ed_sat_reg  [ED_LAT];
    logic                     ed_zero_reg [ED_LAT];
    logic [OUT_W-1:0]         e_quo;

    // combinational helpers
    logic signed [SUM_W-1:0]  dot_next;
    logic [SUM_W-1:0]         mag_next;
    logic [F+1:0]             qp1;
    logic [F:0]               half_q;
    logic [NUM_W-1:0]         num;
    logic [NUM_W-1:0]         num_r;
    logic [F-1:0]             hi;
    logic                     sat_next;

    always_comb
    begin
        dot_next = SUM_W'(pdx_b_reg) + SUM_W'(pdy_b_reg) + SUM_W'(pdz_b_reg);
        mag_next = sq_dot_reg[SQ_LAT-1][SUM_W-1]
                 ? SUM_W'(-sq_dot_reg[SQ_LAT-1]) : SUM_W'(sq_dot_reg[SQ_LAT-1]);
        qp1      = (F+2)'(cos_q) + (F+2)'(1);
        half_q   = qp1[F+1:1];
        num      = neg_k_reg ? ONE_SQ + NUM_W'(bc_k_reg) : ONE_SQ - NUM_W'(bc_k_reg);
        num_r    = num + HALF;
        hi       = n_n_reg[NW-1:OUT_W];
        sat_next = DDW'(hi) >= dd_n_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // A
            ax_a_reg   <= ax_next;
            ay_a_reg   <= ay_next;
            az_a_reg   <= az_next;
            bx_a_reg   <= bx_next;
            by_a_reg   <= by_next;
            bz_a_reg   <= bz_next;
            beta_a_reg <= beta_next;
            en_a_reg   <= measured_energy;
            // B
            sax_b_reg  <= ax_a_reg * ax_a_reg;
            say_b_reg  <= ay_a_reg * ay_a_reg;
            saz_b_reg  <= az_a_reg * az_a_reg;
            sbx_b_reg  <= bx_a_reg * bx_a_reg;
            sby_b_reg  <= by_a_reg * by_a_reg;
            sbz_b_reg  <= bz_a_reg * bz_a_reg;
            pdx_b_reg  <= ax_a_reg * bx_a_reg;
            pdy_b_reg  <= ay_a_reg * by_a_reg;
            pdz_b_reg  <= az_a_reg * bz_a_reg;
            bb_b_reg   <= beta_a_reg * beta_a_reg;
            beta_b_reg <= beta_a_reg;
            en_b_reg   <= en_a_reg;
            zero_b_reg <= (ax_a_reg == '0 && ay_a_reg == '0 && az_a_reg == '0)
                       || (bx_a_reg == '0 && by_a_reg == '0 && bz_a_reg == '0);
            // C (squares are non-negative)
            s1_c_reg   <= SUM_W'(unsigned'(sax_b_reg)) + SUM_W'(unsigned'(say_b_reg))
                        + SUM_W'(unsigned'(saz_b_reg));
            s2_c_reg   <= SUM_W'(unsigned'(sbx_b_reg)) + SUM_W'(unsigned'(sby_b_reg))
                        + SUM_W'(unsigned'(sbz_b_reg));
            dot_c_reg  <= dot_next;
            dsq_c_reg  <= ONE_SQD - DSQ_W'(bb_b_reg);
            beta_c_reg <= beta_b_reg;
            en_c_reg   <= en_b_reg;
            zero_c_reg <= zero_b_reg;
            // side line, square roots
            sq_dot_reg[0]  <= dot_c_reg;
            sq_zero_reg[0] <= zero_c_reg;
            sq_beta_reg[0] <= beta_c_reg;
            sq_dsq_reg[0]  <= dsq_c_reg;
            sq_en_reg[0]   <= en_c_reg;
            for (int k = 1; k < SQ_LAT; k++)
            begin
                sq_dot_reg[k]  <= sq_dot_reg[k-1];
                sq_zero_reg[k] <= sq_zero_reg[k-1];
                sq_beta_reg[k] <= sq_beta_reg[k-1];
                sq_dsq_reg[k]  <= sq_dsq_reg[k-1];
                sq_en_reg[k]   <= sq_en_reg[k-1];
            end
            // P
            p_p_reg    <= SUM_W'(len1) * SUM_W'(len2);
            mag_p_reg  <= mag_next;
            neg_p_reg  <= sq_dot_reg[SQ_LAT-1][SUM_W-1];
            zero_p_reg <= sq_zero_reg[SQ_LAT-1];
            beta_p_reg <= sq_beta_reg[SQ_LAT-1];
            dsq_p_reg  <= sq_dsq_reg[SQ_LAT-1];
            en_p_reg   <= sq_en_reg[SQ_LAT-1];
            // Q: |dot| >= |a||b| means |cos| is exactly one
            clamp_q_reg <= mag_p_reg >= p_p_reg;
            rem_q_reg   <= (mag_p_reg >= p_p_reg) ? '0 : mag_p_reg;
            p_q_reg     <= p_p_reg;
            neg_q_reg   <= neg_p_reg;
            zero_q_reg  <= zero_p_reg;
            beta_q_reg  <= beta_p_reg;
            dsq_q_reg   <= dsq_p_reg;
            en_q_reg    <= en_p_reg;
            // side line, cosine divider
            cd_clamp_reg[0] <= clamp_q_reg;
            cd_neg_reg[0]   <= neg_q_reg;
            cd_zero_reg[0]  <= zero_q_reg;
            cd_beta_reg[0]  <= beta_q_reg;
            cd_en_reg[0]    <= en_q_reg;
            for (int k = 1; k < CD_LAT; k++)
            begin
                cd_clamp_reg[k] <= cd_clamp_reg[k-1];
                cd_neg_reg[k]   <= cd_neg_reg[k-1];
                cd_zero_reg[k]  <= cd_zero_reg[k-1];
                cd_beta_reg[k]  <= cd_beta_reg[k-1];
                cd_en_reg[k]    <= cd_en_reg[k-1];
            end
            // M: round quotient half up, clamp to one
            cmag_m_reg <= (cd_clamp_reg[CD_LAT-1] || half_q > ONE) ? ONE : half_q;
            d_m_reg    <= d_root;
            neg_m_reg  <= cd_neg_reg[CD_LAT-1];
            zero_m_reg <= cd_zero_reg[CD_LAT-1];
            beta_m_reg <= cd_beta_reg[CD_LAT-1];
            en_m_reg   <= cd_en_reg[CD_LAT-1];
            // K
            bc_k_reg   <= (2*F+1)'(beta_m_reg) * (2*F+1)'(cmag_m_reg);
            d_k_reg    <= d_m_reg;
            neg_k_reg  <= neg_m_reg;
            zero_k_reg <= zero_m_reg;
            en_k_reg   <= en_m_reg;
            // G
            g_g_reg    <= GW'(num_r >> F);
            d_g_reg    <= d_k_reg;
            zero_g_reg <= zero_k_reg;
            en_g_reg   <= en_k_reg;
            // E
            eg_e_reg   <= EGW'(en_g_reg) * EGW'(g_g_reg);
            d_e_reg    <= d_g_reg;
            zero_e_reg <= zero_g_reg;
            // N: (2*E*g + d) / (2*d) rounds half up
            n_n_reg    <= NW'({eg_e_reg, 1'b0}) + NW'(d_e_reg);
            dd_n_reg   <= {d_e_reg, 1'b0};
            zero_n_reg <= zero_e_reg;
            // S: quotient fits 24 bits only when the top part is below divisor
            sat_s_reg  <= sat_next;
            rem_s_reg  <= sat_next ? '0 : DDW'(hi);
            low_s_reg  <= n_n_reg[OUT_W-1:0];
            dd_s_reg   <= dd_n_reg;
            zero_s_reg <= zero_n_reg;
            // side line, energy divider
            ed_sat_reg[0]  <= sat_s_reg;
            ed_zero_reg[0] <= zero_s_reg;
            for (int k = 1; k < ED_LAT; k++)
            begin
                ed_sat_reg[k]  <= ed_sat_reg[k-1];
                ed_zero_reg[k] <= ed_zero_reg[k-1];
            end
        end
    end

    dec_isqrt #(.W(SUM_W)) u_len1 (
        .clk  (clk),
        .adv  (adv),
        .x    (s1_c_reg),
        .root (len1)
    );

    dec_isqrt #(.W(SUM_W)) u_len2 (
        .clk  (clk),
        .adv  (adv),
        .x    (s2_c_reg),
        .root (len2)
    );

    dec_div #(.DW(SUM_W), .STEPS(CD_LAT)) u_cos_div (
        .clk  (clk),
        .adv  (adv),
        .rem0 (rem_q_reg),
        .low  ('0),
        .div  (p_q_reg),
        .quo  (cos_q)
    );

    // sqrt(1 - beta^2): same depth as the cosine divider
    dec_isqrt #(.W(DSQ_W)) u_gamma_sqrt (
        .clk  (clk),
        .adv  (adv),
        .x    (dsq_q_reg),
        .root (d_root)
    );

    dec_div #(.DW(DDW), .STEPS(ED_LAT)) u_energy_div (
        .clk  (clk),
        .adv  (adv),
        .rem0 (rem_s_reg),
        .low  (low_s_reg),
        .div  (dd_s_reg),
        .quo  (e_quo)
    );

    // ---------------------------------------------------------------
    // Result selection and output register with skid
    // ---------------------------------------------------------------
    logic [OUT_W-1:0] fin_energy;
    status_t          fin_status;

    always_comb
    begin
        priority if (ed_zero_reg[ED_LAT-1])
        begin
            fin_energy = '0;
            fin_status = STATUS_ZERO;
        end
        else if (ed_sat_reg[ED_LAT-1])
        begin
            fin_energy = '1;
            fin_status = STATUS_SAT;
        end
        else
        begin
            fin_energy = e_quo;
            fin_status = STATUS_OK;
        end
    end

    logic             out_load;
    logic             pipe_v;
    logic [OUT_W-1:0] out_energy_reg, skid_energy_reg;
    status_t          out_status_reg, skid_status_reg;

    assign pipe_v   = vld_reg[TOT-1];
    assign out_load = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_v;
            end
        end
        else if (adv && pipe_v)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_energy_reg <= skid_energy_reg;
                out_status_reg <= skid_status_reg;
            end
            else
            begin
                out_energy_reg <= fin_energy;
                out_status_reg <= fin_status;
            end
        end
        else if (adv && pipe_v)
        begin
            skid_energy_reg <= fin_energy;
            skid_status_reg <= fin_status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign doppler_energy = out_energy_reg;
    assign status         = out_status_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STATUS_ZERO) |-> out_energy_reg == '0)
        else $error("zero-length status with non-zero energy");

    a_sat_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STATUS_SAT) |-> out_energy_reg == '1)
        else $error("saturated status without full-scale energy");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && pipe_v && !skid_valid_reg) |=> skid_valid_reg)
        else $error("item leaving pipeline not caught by skid");

endmodule
